[hdl/cubic_newton_horner_root_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the cubic Newton root block
// Shorthand for clocked, reset-qualified implication checks.
// ---------------------------------------------------------------------------
`ifndef CUBIC_NEWTON_HORNER_ROOT_MACROS_SVH
`define CUBIC_NEWTON_HORNER_ROOT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset
`define CNHR_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset
`define CNHR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/cnhr_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cnhr_pkg
// Shared types and codes of the cubic Newton root block.
// ---------------------------------------------------------------------------
package cnhr_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int TOL_W      = 16;
   localparam int LIMIT_W    = 5;
   localparam int STEP_IDX_W = 5;
   localparam int STAT_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int RSP_DATA_W = 200;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_RUN   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_CONV  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LIMIT = 2'd2;
   localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_LIMIT = 3'd5;

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL  = 9'b000000010,
      ST_RND  = 9'b000000100,
      ST_ACC  = 9'b000001000,
      ST_EMIT = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_UPD  = 9'b001000000,
      ST_TOL  = 9'b010000000,
      ST_CMP  = 9'b100000000
   } state_type;

   // Horner terms, in evaluation order
   typedef enum logic [2:0] {
      OP_B2 = 3'd0,
      OP_B1 = 3'd1,
      OP_B0 = 3'd2,
      OP_C2 = 3'd3,
      OP_C1 = 3'd4
   } op_type;

endpackage

[hdl/cnhr_divider.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cnhr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module cnhr_divider #(
   parameter int NUM_W = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              numer,
   input  logic [cnhr_pkg::DATA_W-1:0]   denom,
   output logic                          done,
   output logic [NUM_W-1:0]              quot
);
   import cnhr_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [NUM_W-1:0]      quo_ff, quo_in;
   logic [DATA_W:0]       trial;
   logic [DATA_W:0]       trial_sub;
   logic                  fits;

   // shift one numerator bit into the partial remainder and try the subtract
   always_comb begin
      trial     = {rem_ff, quo_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, denom};
      fits      = trial >= {1'b0, denom};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = numer;
      end else if (run_ff) begin
         rem_in = fits ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[hdl/cubic_newton_horner_root.sv]
`timescale 1ns / 1ps
// Sequence: the step 0 word comes from five Horner multiply-accumulate terms on the guess;
//   each Newton step then adds the bit-serial divide (a 32 + FRAC_BITS bit quotient, 48
//   at Q16.16), update and tolerance test, and the shared multiply-accumulate run 5 times.
// Throughput: one solve at a time, up to MAX_STEPS + 1 words; the next guess is taken
//   once the final word is queued.
// Reset: synchronous, active high; p(x) = x^3 - 2x^2 - 4x + 4, tolerance 197, limit 20.
// ---------------------------------------------------------------------------
// cubic_newton_horner_root
// Newton refinement of a cubic root using Horner synthetic division, with one
// shared saturating multiply-accumulate unit and a serial divider.
// ---------------------------------------------------------------------------
module cubic_newton_horner_root #(
   parameter int MAX_STEPS = 20,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [31:0] start_guess
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cnhr_pkg::DATA_W-1:0]       req_tdata,
   // rsp_tdata: [4:0] step_index, [36:5] estimate, [68:37] quot_b2,
   //   [100:69] quot_b1, [132:101] residual, [164:133] deriv_c2,
   //   [196:165] slope, [199:197] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cnhr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: [1:0] status
   output logic [cnhr_pkg::STAT_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cnhr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cnhr_pkg::DATA_W-1:0]       csr_data
);
   import cnhr_pkg::*;

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int LIM_W  = (STEP_W > LIMIT_W) ? STEP_W : LIMIT_W;
   localparam int NUM_W  = DATA_W + FRAC_BITS;
   localparam int PROD_W = 2 * (DATA_W + 1);

   localparam logic signed [DATA_W-1:0] COEF_0_RST = DATA_W'(4 << FRAC_BITS);
   localparam logic signed [DATA_W-1:0] COEF_1_RST = DATA_W'(-(4 << FRAC_BITS));
   localparam logic signed [DATA_W-1:0] COEF_2_RST = DATA_W'(-(2 << FRAC_BITS));
   localparam logic signed [DATA_W-1:0] COEF_3_RST = DATA_W'(1 << FRAC_BITS);
   localparam logic [TOL_W-1:0]         TOL_RST    = 16'd197;
   localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 5'd20;

   localparam logic signed [PROD_W-1:0] RND_BIAS = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] SAT_HI   = PROD_W'(33'sh0_7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_LO   = PROD_W'(33'sh1_8000_0000);
   localparam logic signed [DATA_W-1:0] MAX_VAL  = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN_VAL  = 32'sh8000_0000;

   // configuration
   logic signed [DATA_W-1:0]  coef_0_ff, coef_1_ff, coef_2_ff, coef_3_ff;
   logic [TOL_W-1:0]          tol_ff;
   logic [LIMIT_W-1:0]        limit_ff;

   // sequencer
   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic                      first_ff, first_in;
   logic                      conv_ff, conv_in;

   // datapath
   logic signed [DATA_W-1:0]  x_ff, x_in;
   logic signed [DATA_W-1:0]  b2_ff, b1_ff, b0_ff, c2_ff, c1_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [DATA_W-1:0]  rnd_ff, rnd_in;
   logic [DATA_W:0]           diff_ff, diff_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [STAT_W-1:0]         rsp_user_ff;
   logic                      rsp_last_ff;

   // shared unit signals
   logic signed [DATA_W-1:0]  mac_m, mac_k;
   logic signed [DATA_W:0]    mul_a, mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  rnd_sum, rnd_shift;
   logic signed [DATA_W:0]    acc_sum;
   logic signed [DATA_W-1:0]  acc_val;
   logic [DATA_W-1:0]         x_mag, b0_mag, c1_mag;

   // divider and update
   logic                      div_start, div_done;
   logic [NUM_W-1:0]          div_numer, div_quot;
   logic                      div_neg;
   logic signed [NUM_W+1:0]   dx, x_wide;
   logic signed [DATA_W-1:0]  x_new;
   logic signed [DATA_W:0]    step_diff;

   // emit
   logic [LIM_W-1:0]          lim_eff;
   logic                      hit_limit;
   logic [STAT_W-1:0]         emit_stat;
   logic                      emit_last;
   logic                      out_free;
   logic                      emit_load;
   logic                      accept;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   // magnitudes of signed words, exact as 32-bit unsigned
   assign x_mag  = x_ff[DATA_W-1]  ? DATA_W'(-x_ff)  : DATA_W'(x_ff);
   assign b0_mag = b0_ff[DATA_W-1] ? DATA_W'(-b0_ff) : DATA_W'(b0_ff);
   assign c1_mag = c1_ff[DATA_W-1] ? DATA_W'(-c1_ff) : DATA_W'(c1_ff);

   // select the Horner term: multiplier coefficient and addend
   always_comb begin
      unique case (op_ff)
         OP_B2: begin
            mac_m = coef_3_ff;
            mac_k = coef_2_ff;
         end
         OP_B1: begin
            mac_m = b2_ff;
            mac_k = coef_1_ff;
         end
         OP_B0: begin
            mac_m = b1_ff;
            mac_k = coef_0_ff;
         end
         OP_C2: begin
            mac_m = coef_3_ff;
            mac_k = b2_ff;
         end
         OP_C1: begin
            mac_m = c2_ff;
            mac_k = b1_ff;
         end
         default: begin
            mac_m = coef_3_ff;
            mac_k = coef_2_ff;
         end
      endcase
   end

   // shared multiplier: Horner products, or tolerance times |x|
   always_comb begin
      if (state_ff == ST_TOL) begin
         mul_a = {{(DATA_W + 1 - TOL_W){1'b0}}, tol_ff};
         mul_b = {1'b0, x_mag};
      end else begin
         mul_a = {mac_m[DATA_W-1], mac_m};
         mul_b = {x_ff[DATA_W-1], x_ff};
      end
      prod_in = mul_a * mul_b;
   end

   // round half up, floor shift, saturate
   always_comb begin
      rnd_sum   = prod_ff + RND_BIAS;
      rnd_shift = rnd_sum >>> FRAC_BITS;
      if (rnd_shift > SAT_HI)
         rnd_in = MAX_VAL;
      else if (rnd_shift < SAT_LO)
         rnd_in = MIN_VAL;
      else
         rnd_in = rnd_shift[DATA_W-1:0];
   end

   // saturating accumulate
   always_comb begin
      acc_sum = {mac_k[DATA_W-1], mac_k} + {rnd_ff[DATA_W-1], rnd_ff};
      if (acc_sum[DATA_W] != acc_sum[DATA_W-1])
         acc_val = acc_sum[DATA_W] ? MIN_VAL : MAX_VAL;
      else
         acc_val = acc_sum[DATA_W-1:0];
   end

   // Newton update from the divider quotient
   assign div_numer = (NUM_W'(b0_mag) << FRAC_BITS) + NUM_W'(c1_mag >> 1);
   assign div_neg   = b0_ff[DATA_W-1] ^ c1_ff[DATA_W-1];

   always_comb begin
      dx     = div_neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
      x_wide = (NUM_W + 2)'(x_ff) - dx;
      if (x_wide > (NUM_W + 2)'(MAX_VAL))
         x_new = MAX_VAL;
      else if (x_wide < (NUM_W + 2)'(MIN_VAL))
         x_new = MIN_VAL;
      else
         x_new = x_wide[DATA_W-1:0];
      step_diff = {x_new[DATA_W-1], x_new} - {x_ff[DATA_W-1], x_ff};
      diff_in   = step_diff[DATA_W] ? (DATA_W + 1)'(-step_diff) : (DATA_W + 1)'(step_diff);
   end

   // status of the estimate now in hand
   always_comb begin
      if (limit_ff == '0)
         lim_eff = LIM_W'(1);
      else if (LIM_W'(limit_ff) > LIM_W'(MAX_STEPS))
         lim_eff = LIM_W'(MAX_STEPS);
      else
         lim_eff = LIM_W'(limit_ff);
      hit_limit = LIM_W'(step_ff) >= lim_eff;

      if (first_ff)
         emit_stat = (c1_ff == '0) ? STAT_ZERO : STAT_RUN;
      else if (conv_ff)
         emit_stat = STAT_CONV;
      else if (hit_limit)
         emit_stat = STAT_LIMIT;
      else if (c1_ff == '0)
         emit_stat = STAT_ZERO;
      else
         emit_stat = STAT_RUN;
      emit_last = (emit_stat != STAT_RUN);
   end

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_load = (state_ff == ST_EMIT) && out_free;
   assign div_start = emit_load && !emit_last;

   // sequencer
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      step_in  = step_ff;
      first_in = first_ff;
      conv_in  = conv_ff;
      x_in     = x_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in     = req_tdata;
               step_in  = '0;
               first_in = 1'b1;
               conv_in  = 1'b0;
               op_in    = OP_B2;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_RND;
         ST_RND: state_in = ST_ACC;
         ST_ACC: begin
            if (op_ff == OP_C1) begin
               state_in = ST_EMIT;
            end else begin
               op_in    = op_type'(op_ff + 3'd1);
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            if (out_free)
               state_in = emit_last ? ST_IDLE : ST_DIV;
         end
         ST_DIV: begin
            if (div_done)
               state_in = ST_UPD;
         end
         ST_UPD: begin
            x_in     = x_new;
            step_in  = step_ff + 1'b1;
            first_in = 1'b0;
            state_in = ST_TOL;
         end
         ST_TOL: state_in = ST_CMP;
         ST_CMP: begin
            conv_in  = PROD_W'({diff_ff, {TOL_W{1'b0}}}) <= $unsigned(prod_ff);
            op_in    = OP_B2;
            state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // drop the output word once taken, refill from the emit state
   always_comb begin
      if (emit_load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_B2;
         step_ff      <= '0;
         first_ff     <= 1'b0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         coef_0_ff    <= COEF_0_RST;
         coef_1_ff    <= COEF_1_RST;
         coef_2_ff    <= COEF_2_RST;
         coef_3_ff    <= COEF_3_RST;
         tol_ff       <= TOL_RST;
         limit_ff     <= LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         first_ff     <= first_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_COEF_0:     coef_0_ff <= csr_data;
               CSR_COEF_1:     coef_1_ff <= csr_data;
               CSR_COEF_2:     coef_2_ff <= csr_data;
               CSR_COEF_3:     coef_3_ff <= csr_data;
               CSR_TOLERANCE:  tol_ff    <= csr_data[TOL_W-1:0];
               CSR_STEP_LIMIT: limit_ff  <= csr_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      if (state_ff == ST_MUL || state_ff == ST_TOL)
         prod_ff <= prod_in;
      if (state_ff == ST_RND)
         rnd_ff <= rnd_in;
      if (state_ff == ST_UPD)
         diff_ff <= diff_in;
      if (state_ff == ST_ACC) begin
         unique case (op_ff)
            OP_B2:   b2_ff <= acc_val;
            OP_B1:   b1_ff <= acc_val;
            OP_B0:   b0_ff <= acc_val;
            OP_C2:   c2_ff <= acc_val;
            OP_C1:   c1_ff <= acc_val;
            default: ;
         endcase
      end
      if (emit_load) begin
         rsp_data_ff <= {3'b000, c1_ff, c2_ff, b0_ff, b1_ff, b2_ff, x_ff,
                         STEP_IDX_W'(step_ff)};
         rsp_user_ff <= emit_stat;
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   cnhr_divider #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (c1_mag),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule

[hdl/cnhr_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cnhr_checker
// Port-level checks of the cubic Newton root block, bound to the top level.
// ---------------------------------------------------------------------------
`include "cubic_newton_horner_root_macros.svh"

module cnhr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cnhr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [cnhr_pkg::STAT_W-1:0]       rsp_tuser,
   input logic                              rsp_tlast
);
   import cnhr_pkg::*;

   // a taken guess starts a solve; no second guess right behind it
   `CNHR_ASSERT_NEXT(a_busy_after_req, req_tvalid && req_tready, !req_tready,
                     "guess taken while solving")

   // the final word of a solve is exactly the one with a stop status
   `CNHR_ASSERT_SAME(a_last_matches_status, rsp_tvalid,
                     rsp_tlast == (rsp_tuser != STAT_RUN), "tlast and status disagree")

   // while a running word is pending the solve is still in progress
   `CNHR_ASSERT_SAME(a_no_req_mid_solve, rsp_tvalid && !rsp_tlast, !req_tready,
                     "guess accepted mid solve")

   // a stalled result word holds
   `CNHR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast),
                     "stalled result changed")

endmodule

bind cubic_newton_horner_root cnhr_checker u_cnhr_checker (.*);
